// ----- design/lfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsp_pkg
// Shared constants and types for the line frame serial packer.
// ----------------------------------------------------------------------------
package lfsp_pkg;

   localparam int PIXELS = 1024;
   localparam int IDX_W  = (PIXELS > 2) ? $clog2(PIXELS) : 1;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXELS - 1);

   localparam logic [7:0]  SYNC_A         = 8'hAF;
   localparam logic [7:0]  SYNC_B         = 8'hA6;
   localparam logic [15:0] FRAME_LEN      = 16'(2 * PIXELS + 7);
   localparam logic [15:0] EXPOSURE_RESET = 16'd250;

   typedef struct packed {
      logic [15:0] pixel;
      logic [15:0] exposure;
      logic        first;
      logic        last;
   } entry_type;

endpackage

// ----- design/lfsp_if.sv -----
// ----------------------------------------------------------------------------
// lfsp channel interfaces
// Valid/ready channels for requests, response bytes and the exposure write.
// ----------------------------------------------------------------------------
interface lfsp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_sample;

   modport source (output valid, output pixel_sample, input ready);
   modport sink   (input valid, input pixel_sample, output ready);
   modport mon    (input valid, input pixel_sample, input ready);
endinterface

interface lfsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, output out_byte, output run_last, output frame_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input frame_end,
                   output ready);
   modport mon    (input valid, input out_byte, input run_last, input frame_end,
                   input ready);
endinterface

interface lfsp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] exposure_us;

   modport source (output valid, output exposure_us, input ready);
   modport sink   (input valid, input exposure_us, output ready);
   modport mon    (input valid, input exposure_us, input ready);
endinterface

// ----- design/line_frame_serial_packer_unit.sv -----
// ----------------------------------------------------------------------------
// line_frame_serial_packer_unit
// Frames 16-bit pixel requests into a header, pixel and checksum byte stream.
// ----------------------------------------------------------------------------
// Path: a request passes the queue slot, the current-entry register and the
// single-byte output register. Throughput: one byte per cycle while ready
// is high; two bytes per pixel, eight on a frame's first, three on its last.
// Reset: synchronous; drops any partial frame and queued requests, restores
// exposure to 250 and restarts at the header.
// ----------------------------------------------------------------------------
module line_frame_serial_packer_unit
   import lfsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lfsp_req_if.sink   req_ch,
   lfsp_csr_if.sink   csr_ch,
   lfsp_rsp_if.source rsp_ch
);

   entry_type push_data;
   entry_type pop_data;
   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_not_empty;

   lfsp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   lfsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   lfsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ----- design/lfsp_front.sv -----
// ----------------------------------------------------------------------------
// lfsp_front
// Accept requests, tag first and last pixel of the frame, hold exposure.
// ----------------------------------------------------------------------------
module lfsp_front
   import lfsp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   lfsp_req_if.sink        req_ch,
   lfsp_csr_if.sink        csr_ch,
   input  logic            q_full,
   output logic            q_push,
   output entry_type       q_data
);

   logic [IDX_W-1:0] index_ff, index_in;
   logic [15:0]      exposure_ff, exposure_in;
   logic             is_last;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;
   assign is_last      = (index_ff == LAST_IDX);

   assign q_data.pixel    = req_ch.pixel_sample;
   assign q_data.exposure = exposure_ff;
   assign q_data.first    = (index_ff == '0);
   assign q_data.last     = is_last;

   always_comb begin
      index_in    = index_ff;
      exposure_in = exposure_ff;
      if (q_push) begin
         index_in = is_last ? '0 : index_ff + 1'b1;
      end
      if (csr_ch.valid) begin
         exposure_in = csr_ch.exposure_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= '0;
         exposure_ff <= EXPOSURE_RESET;
      end else begin
         index_ff    <= index_in;
         exposure_ff <= exposure_in;
      end
   end

endmodule

// ----- design/lfsp_queue.sv -----
// ----------------------------------------------------------------------------
// lfsp_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module lfsp_queue
   import lfsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_data
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/lfsp_back.sv -----
// ----------------------------------------------------------------------------
// lfsp_back
// Step through header, pixel and checksum bytes into the output register.
// ----------------------------------------------------------------------------
module lfsp_back
   import lfsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  entry_type  q_data,
   output logic       q_pop,
   lfsp_rsp_if.source rsp_ch
);

   localparam logic [3:0] POS_SYNC_A = 4'd0;
   localparam logic [3:0] POS_SYNC_B = 4'd1;
   localparam logic [3:0] POS_LEN_LO = 4'd2;
   localparam logic [3:0] POS_LEN_HI = 4'd3;
   localparam logic [3:0] POS_EXP_LO = 4'd4;
   localparam logic [3:0] POS_EXP_HI = 4'd5;
   localparam logic [3:0] POS_PIX_LO = 4'd6;
   localparam logic [3:0] POS_PIX_HI = 4'd7;
   localparam logic [3:0] POS_SUM    = 4'd8;

   entry_type  cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       run_last_ff, run_last_in;
   logic       frame_end_ff, frame_end_in;
   logic       advance;
   logic       item_done;
   logic [7:0] byte_sel;

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_byte  = out_byte_ff;
   assign rsp_ch.run_last  = run_last_ff;
   assign rsp_ch.frame_end = frame_end_ff;

   assign advance   = busy_ff && (!out_valid_ff || rsp_ch.ready);
   assign item_done = advance &&
                      ((pos_ff == POS_PIX_HI && !cur_ff.last) || pos_ff == POS_SUM);
   assign q_pop     = q_not_empty && (!busy_ff || item_done);

   always_comb begin
      case (pos_ff)
         POS_SYNC_A: byte_sel = SYNC_A;
         POS_SYNC_B: byte_sel = SYNC_B;
         POS_LEN_LO: byte_sel = FRAME_LEN[7:0];
         POS_LEN_HI: byte_sel = FRAME_LEN[15:8];
         POS_EXP_LO: byte_sel = cur_ff.exposure[7:0];
         POS_EXP_HI: byte_sel = cur_ff.exposure[15:8];
         POS_PIX_LO: byte_sel = cur_ff.pixel[7:0];
         POS_PIX_HI: byte_sel = cur_ff.pixel[15:8];
         default:    byte_sel = sum_ff;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_sel;
         run_last_in  = item_done;
         frame_end_in = (pos_ff == POS_SUM);
         case (pos_ff)
            POS_SYNC_A: sum_in = byte_sel;
            POS_SUM:    sum_in = 8'd0;
            default:    sum_in = sum_ff + byte_sel;
         endcase
         pos_in = (pos_ff == POS_PIX_HI) ? POS_SUM : pos_ff + 4'd1;
      end
      if (item_done) begin
         busy_in = 1'b0;
      end
      if (q_pop) begin
         cur_in  = q_data;
         busy_in = 1'b1;
         pos_in  = q_data.first ? POS_SYNC_A : POS_PIX_LO;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= POS_SYNC_A;
         sum_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
         run_last_ff  <= 1'b0;
         frame_end_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         run_last_ff  <= run_last_in;
         frame_end_ff <= frame_end_in;
      end
   end

endmodule

// ----- design/lfsp_checker.sv -----
// ----------------------------------------------------------------------------
// lfsp_checker
// Port-level checks on the packer's response stream.
// ----------------------------------------------------------------------------
module lfsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_frame_end,
   input logic       csr_ready
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last)
      else $error("checksum byte without run_last");

   a_no_double_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_end
         |=> !(rsp_valid && rsp_frame_end))
      else $error("two checksum bytes in a row");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
         |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last)
             && $stable(rsp_frame_end))
      else $error("stalled response changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("exposure write stalled");

endmodule

bind line_frame_serial_packer_unit lfsp_checker u_lfsp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_run_last  (rsp_ch.run_last),
   .rsp_frame_end (rsp_ch.frame_end),
   .csr_ready     (csr_ch.ready)
);

// ----- sim/line_frame_serial_packer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// line_frame_serial_packer_unit_tb
// Drives pixel requests in random bursts and gaps, writes the exposure between
// phases and checks every header, pixel and checksum byte against a local
// frame packer.
// ----------------------------------------------------------------------------
module line_frame_serial_packer_unit_tb;
   import lfsp_pkg::PIXELS;

   localparam logic [7:0]  SYNC_FIRST     = 8'hAF;
   localparam logic [7:0]  SYNC_SECOND    = 8'hA6;
   localparam logic [15:0] FRAME_LENGTH   = 16'(2 * PIXELS + 7);
   localparam logic [15:0] EXPOSURE_AFTER_RESET = 16'd250;
   localparam int          CYCLE_LIMIT    = 600000;
   localparam int          LONG_HOLD      = 300;
   localparam int          ITEM_COUNT     = 460;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       frame_end;
   } byte_expect_type;

   logic clock;
   logic reset;

   lfsp_req_if req_bus ();
   lfsp_csr_if csr_bus ();
   lfsp_rsp_if rsp_bus ();

   line_frame_serial_packer_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .csr_ch (csr_bus),
      .rsp_ch (rsp_bus)
   );

   logic [15:0]     pixel_pending [$];
   byte_expect_type frame_byte_q [$];
   byte_expect_type want;

   int           pix_pos;
   logic [7:0]   frame_sum;
   logic [15:0]  exposure_shadow;

   int           error_count;
   int           cycle_count;
   int           pixels_accepted;
   int           burst_left;
   int           gap_left;
   int           stall_mode;
   int           mode_left;
   int           hold_left;
   bit           long_hold_done;

   logic [15:0] directed_px [20] = '{
      16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0001, 16'h8000, 16'h7FFF,
      16'hAAAA, 16'h5555, 16'h00AF, 16'hA6A6, 16'h1234,
      16'hFFFF, 16'h0000, 16'hFFFE, 16'h0100, 16'h00FE, 16'hFEFF, 16'h8001,
      16'h4321
   };

   function automatic void push_frame_byte(input logic [7:0] b);
      frame_byte_q.push_back('{b, 1'b0, 1'b0});
      frame_sum = frame_sum + b;
   endfunction

   task automatic pack_pixel(input logic [15:0] px);
      byte_expect_type tail;
      if (pix_pos == 0) begin
         frame_sum = 8'h00;
         push_frame_byte(SYNC_FIRST);
         push_frame_byte(SYNC_SECOND);
         push_frame_byte(FRAME_LENGTH[7:0]);
         push_frame_byte(FRAME_LENGTH[15:8]);
         push_frame_byte(exposure_shadow[7:0]);
         push_frame_byte(exposure_shadow[15:8]);
      end
      push_frame_byte(px[7:0]);
      push_frame_byte(px[15:8]);
      pix_pos++;
      if (pix_pos >= PIXELS) begin
         frame_byte_q.push_back('{frame_sum, 1'b0, 1'b1});
         pix_pos   = 0;
         frame_sum = 8'h00;
      end
      tail = frame_byte_q.pop_back();
      tail.run_last = 1'b1;
      frame_byte_q.push_back(tail);
   endtask

   task automatic wait_idle();
      while (pixel_pending.size() != 0 || req_bus.valid || frame_byte_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_exposure(input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.exposure_us <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid   <= 1'b0;
      exposure_shadow = value;
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pack_pixel(req_bus.pixel_sample);
            pixels_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               req_bus.valid <= 1'b0;
               gap_left--;
            end else if (pixel_pending.size() != 0) begin
               req_bus.valid        <= 1'b1;
               req_bus.pixel_sample <= pixel_pending.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
               end else begin
                  burst_left--;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response sink stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode = 0;
         mode_left  = 0;
         hold_left  = 0;
      end else begin
         if (!long_hold_done && req_bus.valid && pixels_accepted >= 200) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 150);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: begin
                  rsp_bus.ready <= 1'b1;
               end
               1: begin
                  rsp_bus.ready <= $urandom_range(0, 1);
               end
               2: begin
                  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_bus.ready <= ((cycle_count % 5) < 3);
               end
            endcase
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_byte_q.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual data=%h last=%b end=%b",
                     $time, rsp_bus.out_byte, rsp_bus.run_last, rsp_bus.frame_end);
            error_count++;
         end else begin
            want = frame_byte_q.pop_front();
            if ({rsp_bus.out_byte, rsp_bus.run_last, rsp_bus.frame_end} !== want) begin
               $display({"%0t: byte mismatch: expected data=%h last=%b end=%b, ",
                         "actual data=%h last=%b end=%b"},
                        $time, want.data, want.run_last, want.frame_end,
                        rsp_bus.out_byte, rsp_bus.run_last, rsp_bus.frame_end);
               error_count++;
            end
         end
      end
   end

   initial begin
      int          total;
      int          phase;
      int          n;
      int          to_boundary;
      logic [15:0] px;

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.pixel_sample = 16'h0000;
      csr_bus.valid        = 1'b0;
      csr_bus.exposure_us  = 16'h0000;
      rsp_bus.ready        = 1'b0;
      exposure_shadow      = EXPOSURE_AFTER_RESET;
      pix_pos              = 0;
      frame_sum            = 8'h00;
      error_count          = 0;
      cycle_count          = 0;
      pixels_accepted      = 0;
      long_hold_done       = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first frame header carries the reset exposure
      for (int i = 0; i < 12; i++) pixel_pending.push_back(directed_px[i]);
      wait_idle();
      // exposure change mid-frame leaves the current frame's bytes unchanged
      write_exposure(16'hFFFF);
      for (int i = 12; i < 20; i++) pixel_pending.push_back(directed_px[i]);
      total = 20;
      wait_idle();

      phase = 0;
      while (total < ITEM_COUNT) begin
         n           = $urandom_range(20, 120);
         if (n > ITEM_COUNT - total) n = ITEM_COUNT - total;
         to_boundary = PIXELS - (total % PIXELS);
         if (n > to_boundary) n = to_boundary;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
               px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
               px = 16'($urandom_range(0, 65535));
            pixel_pending.push_back(px);
         end
         total += n;
         wait_idle();
         case (phase % 4)
            0: begin
               write_exposure(16'h0000);
            end
            1: begin
               write_exposure(16'hFFFF);
            end
            default: begin
               write_exposure(16'($urandom_range(0, 65535)));
            end
         endcase
         phase++;
      end

      wait_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0 && frame_byte_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
design/lfsp_pkg.sv
design/lfsp_if.sv
design/lfsp_front.sv
design/lfsp_queue.sv
design/lfsp_back.sv
design/line_frame_serial_packer_unit.sv
design/lfsp_checker.sv
sim/line_frame_serial_packer_unit_tb.sv
